// ----- design/dcs_pkg.sv -----
// Shared constants and types for the deadline callout scheduler.
// No dependencies.
`default_nettype none
package dcs_pkg;
    localparam int SLOTS     = 16;
    localparam int MAX_FIRES = 31;
    localparam int SLOT_AW   = $clog2(SLOTS);
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);
    localparam int MIN_W     = 16;
    localparam int MAX_W     = 20;
    localparam int CFG_IW    = 2;

    localparam logic [MIN_W-1:0] MIN_RESET = 16'd50;
    localparam logic [MAX_W-1:0] MAX_RESET = 20'd50000;

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_QUERY  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    localparam logic [CFG_IW-1:0] CFG_MIN = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX = 2'd1;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_FIRE = 7'b0000100,
        ST_UPDT = 7'b0001000,
        ST_ALRM = 7'b0010000,
        ST_ALSL = 7'b0100000,
        ST_STAT = 7'b1000000
    } t_state;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction
endpackage
`default_nettype wire

// ----- design/deadline_callout_scheduler_unit.sv -----
// Deadline callout scheduler: 16 timer slots, deadline and period in one RAM.
// Query and cancel go straight to the status word; arm and tick scan the slot RAM
// one read per cycle, and a tick rescans the slot RAM after each fire it emits.
// One item at a time; o_busy high until the status word goes out.
// Synchronous active-low reset clears active marks and alarm, and loads reset intervals.
// Results are strobed for one cycle; the receiver cannot stall.
`default_nettype none
module deadline_callout_scheduler_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic [1:0]                 i_operation,
    input  wire logic [3:0]                 i_slot,
    input  wire logic [63:0]                i_deadline,
    input  wire logic [63:0]                i_period,
    input  wire logic [63:0]                i_now,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [dcs_pkg::CFG_IW-1:0] i_cfg_index,
    input  wire logic [19:0]                i_cfg_data,
    output logic                            o_valid,
    output logic                            o_kind,
    output logic [3:0]                      o_fired_slot,
    output logic [63:0]                     o_fired_deadline,
    output logic [63:0]                     o_alarm_time,
    output logic                            o_alarm_update,
    output logic                            o_slot_idle,
    output logic                            o_overflow,
    output logic                            o_last
);
    import dcs_pkg::*;

    t_state r_state;
    logic [1:0]  r_op;
    logic [3:0]  r_slot;
    logic [63:0] r_now;
    logic [MIN_W-1:0] r_min;
    logic [MAX_W-1:0] r_max;
    logic [SLOTS-1:0] r_active;
    logic [63:0] r_alarm;
    logic [63:0] r_t, r_m;

    // scan bookkeeping
    logic [SLOT_AW:0]   r_cnt;
    logic               r_rd_vld;
    logic [SLOT_AW-1:0] r_rd_idx;
    logic               r_found;
    logic [SLOT_AW-1:0] r_best;
    logic [63:0]        r_best_dl, r_best_per;
    logic [FIRE_W-1:0]  r_fires;
    logic               r_ovf, r_upd;

    // RAM port
    logic               we;
    logic [SLOT_AW-1:0] waddr, raddr;
    logic [127:0]       wdata, rdata;
    logic               in_table;
    logic [SLOT_AW-1:0] in_idx;

    assign in_idx   = SLOT_AW'(i_slot);
    assign in_table = (32'(i_slot) < SLOTS);
    assign raddr    = r_cnt[SLOT_AW-1:0];
    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        we    = 1'b0;
        waddr = r_best;
        wdata = {r_best_per, sat_add(r_best_dl, r_best_per)};
        if (r_state == ST_IDLE && i_start && t_op'(i_operation) == OP_ARM && in_table) begin
            we    = 1'b1;
            waddr = in_idx;
            wdata = {i_period, i_deadline};
        end else if (r_state == ST_UPDT && r_best_per != 64'd0) begin
            we = 1'b1;
        end
    end

    dcs_ram #(.W(128), .D(SLOTS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MIN) r_min <= i_cfg_data[MIN_W-1:0];
            else if (i_cfg_index == CFG_MAX) r_max <= i_cfg_data[MAX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= '0;
            r_alarm  <= '0;
            o_valid  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_op    <= i_operation;
                        r_slot  <= i_slot;
                        r_now   <= i_now;
                        r_fires <= '0;
                        r_ovf   <= 1'b0;
                        r_upd   <= 1'b0;
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_rd_vld <= 1'b0;
                        o_slot_idle <= 1'b0;
                        unique case (t_op'(i_operation))
                            OP_ARM: begin
                                if (in_table) begin
                                    r_active[in_idx] <= 1'b1;
                                    r_state <= ST_SCAN;
                                end else begin
                                    r_state <= ST_STAT;
                                end
                            end
                            OP_CANCEL: begin
                                if (in_table) r_active[in_idx] <= 1'b0;
                                r_state <= ST_STAT;
                            end
                            OP_QUERY: begin
                                o_slot_idle <= in_table ? ~r_active[in_idx] : 1'b1;
                                r_state <= ST_STAT;
                            end
                            OP_TICK: r_state <= ST_SCAN;
                            default: r_state <= ST_STAT;
                        endcase
                    end
                end
                ST_SCAN: begin
                    // issue one read per cycle, compare the word returned
                    if (32'(r_cnt) < SLOTS) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_rd_vld <= (32'(r_cnt) < SLOTS);
                    r_rd_idx <= raddr;
                    if (r_rd_vld && r_active[r_rd_idx]
                        && (!r_found || rdata[63:0] < r_best_dl)) begin
                        r_found    <= 1'b1;
                        r_best     <= r_rd_idx;
                        r_best_dl  <= rdata[63:0];
                        r_best_per <= rdata[127:64];
                    end
                    // final candidate may still replace the best; judge in ST_ALRM
                    if (r_rd_vld && 32'(r_rd_idx) == SLOTS - 1) begin
                        r_rd_vld <= 1'b0;
                        r_state  <= ST_ALRM;
                    end
                end
                ST_FIRE: begin
                    o_valid          <= 1'b1;
                    o_kind           <= KIND_FIRE;
                    o_fired_slot     <= 4'(r_best);
                    o_fired_deadline <= r_best_dl;
                    o_alarm_time     <= '0;
                    o_alarm_update   <= 1'b0;
                    o_slot_idle      <= 1'b0;
                    o_overflow       <= 1'b0;
                    o_last           <= 1'b0;
                    r_state          <= ST_UPDT;
                end
                ST_UPDT: begin
                    if (r_best_per == 64'd0) r_active[r_best] <= 1'b0;
                    r_fires <= r_fires + 1'b1;
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_ALRM: begin
                    // scan result settled here; decide fire or alarm
                    r_t <= sat_add(r_now, 64'(r_max));
                    r_m <= sat_add(r_now, 64'(r_min));
                    if (t_op'(r_op) == OP_ARM) begin
                        // arm: recompute only if the new slot leads
                        if (r_best != SLOT_AW'(r_slot)) r_state <= ST_STAT;
                        else r_state <= ST_ALSL;
                    end else if (!r_found || r_best_dl > r_now) begin
                        r_state <= ST_ALSL;
                    end else if (32'(r_fires) >= MAX_FIRES) begin
                        r_ovf   <= 1'b1;
                        r_state <= ST_ALSL;
                    end else begin
                        r_state <= ST_FIRE;
                    end
                end
                ST_ALSL: begin
                    if (!r_found) r_alarm <= r_t;
                    else if (r_best_dl <= r_m) r_alarm <= r_m;
                    else if (r_best_dl < r_t) r_alarm <= r_best_dl;
                    else r_alarm <= r_t;
                    r_upd   <= 1'b1;
                    r_state <= ST_STAT;
                end
                ST_STAT: begin
                    o_valid          <= 1'b1;
                    o_kind           <= KIND_STATUS;
                    o_fired_slot     <= '0;
                    o_fired_deadline <= '0;
                    o_alarm_time     <= r_alarm;
                    o_alarm_update   <= r_upd;
                    o_overflow       <= r_ovf;
                    o_last           <= 1'b1;
                    r_state          <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/dcs_ram.sv -----
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module dcs_ram #(
    parameter int W = 128,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- bench/deadline_callout_scheduler_unit_tb.sv -----
// Self-checking bench for the deadline callout scheduler: directed table, then random
// arm/cancel/query/tick words checked against an in-bench predictor of the slot table.
// Depends on dcs_pkg and deadline_callout_scheduler_unit.
`timescale 1ns / 1ps
`default_nettype none
module deadline_callout_scheduler_unit_tb;
    import dcs_pkg::*;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_ITEMS  = 180;
    localparam int DRAIN_CYCLES  = 400;

    // Result word as seen on the output ports.
    typedef struct packed {
        logic        kind;
        logic [3:0]  fired_slot;
        logic [63:0] fired_deadline;
        logic [63:0] alarm_time;
        logic        alarm_update;
        logic        slot_idle;
        logic        overflow;
        logic        last;
    } t_result;

    // One stimulus row; chk marks rows whose status word is typed in directly.
    typedef struct {
        t_op         op;
        logic [3:0]  slot;
        logic [63:0] deadline;
        logic [63:0] period;
        logic [63:0] now;
        bit          chk;
        logic [63:0] alarm;
        logic        upd;
        logic        idle;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_operation = '0;
    logic [3:0]  i_slot = '0;
    logic [63:0] i_deadline = '0;
    logic [63:0] i_period = '0;
    logic [63:0] i_now = '0;
    logic        i_cfg_valid = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;
    logic        o_busy, o_cfg_ready, o_valid, o_kind, o_alarm_update;
    logic        o_slot_idle, o_overflow, o_last;
    logic [3:0]  o_fired_slot;
    logic [63:0] o_fired_deadline, o_alarm_time;

    deadline_callout_scheduler_unit i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: mirror of the slot table, alarm and interval registers.
    logic [63:0] mdl_deadline [SLOTS];
    logic [63:0] mdl_period [SLOTS];
    logic        mdl_active [SLOTS];
    logic [63:0] mdl_alarm;
    logic [63:0] mdl_min_iv, mdl_max_iv;

    t_result pending_words[$];
    int      mismatches = 0;
    bit      idle_gaps = 1'b1;
    logic [63:0] clock_now = '0;
    t_row    rows [DIRECTED_ROWS];

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? ALL_ONES : s[63:0];
    endfunction

    // Earliest active slot, lowest index on ties; -1 when the table is empty.
    function automatic int earliest_slot();
        int best;
        best = -1;
        for (int i = 0; i < SLOTS; i++)
            if (mdl_active[i] && (best < 0 || mdl_deadline[i] < mdl_deadline[best]))
                best = i;
        return best;
    endfunction

    function automatic void update_alarm(logic [63:0] now);
        logic [63:0] t, m, a;
        int h;
        t = add_sat(now, mdl_max_iv);
        m = add_sat(now, mdl_min_iv);
        a = t;
        h = earliest_slot();
        if (h >= 0) begin
            if (mdl_deadline[h] <= m) a = m;
            else if (mdl_deadline[h] < t) a = mdl_deadline[h];
        end
        mdl_alarm = a;
    endfunction

    // Queue the fire words and the status word that one item causes.
    task automatic predict_words(t_op op, logic [3:0] s, logic [63:0] dl,
                                 logic [63:0] per, logic [63:0] now);
        t_result w;
        int h, fires;
        logic upd, idle, ovf;
        upd = 0; idle = 0; ovf = 0; fires = 0;
        case (op)
            OP_ARM: begin
                mdl_deadline[s] = dl;
                mdl_period[s] = per;
                mdl_active[s] = 1'b1;
                if (earliest_slot() == int'(s)) begin
                    update_alarm(now);
                    upd = 1;
                end
            end
            OP_CANCEL: begin
                mdl_active[s] = 1'b0;
                mdl_deadline[s] = '0;
                mdl_period[s] = '0;
            end
            OP_QUERY: idle = !mdl_active[s];
            default: begin
                forever begin
                    h = earliest_slot();
                    if (h < 0 || mdl_deadline[h] > now) break;
                    if (fires >= MAX_FIRES) begin
                        ovf = 1;
                        break;
                    end
                    w = '0;
                    w.kind = KIND_FIRE;
                    w.fired_slot = h[3:0];
                    w.fired_deadline = mdl_deadline[h];
                    pending_words.push_back(w);
                    fires++;
                    if (mdl_period[h] != 0) begin
                        mdl_deadline[h] = add_sat(mdl_deadline[h], mdl_period[h]);
                    end else begin
                        mdl_active[h] = 1'b0;
                        mdl_deadline[h] = '0;
                    end
                end
                update_alarm(now);
                upd = 1;
            end
        endcase
        w = '0;
        w.kind = KIND_STATUS;
        w.alarm_time = mdl_alarm;
        w.alarm_update = upd;
        w.slot_idle = idle;
        w.overflow = ovf;
        w.last = 1'b1;
        pending_words.push_back(w);
    endtask

    // Check every strobed word against the oldest expected one.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid) begin
            got = {o_kind, o_fired_slot, o_fired_deadline, o_alarm_time,
                   o_alarm_update, o_slot_idle, o_overflow, o_last};
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected word %h", got);
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word mismatch exp %h got %h", want, got);
                end
            end
        end
    end

    task automatic random_gap();
        if (idle_gaps)
            while ($urandom_range(99) < 26) @(negedge i_clk);
    endtask

    // Present one item at the falling edge, hold until accepted.
    task automatic send_item(t_row r);
        // keep start low across a falling edge after the last drop
        @(negedge i_clk);
        random_gap();
        i_start <= 1'b1;
        i_operation <= r.op;
        i_slot <= r.slot;
        i_deadline <= r.deadline;
        i_period <= r.period;
        i_now <= r.now;
        do @(posedge i_clk); while (o_busy);
        predict_words(r.op, r.slot, r.deadline, r.period, r.now);
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write one interval register; only called with the block idle.
    task automatic write_interval(logic [CFG_IW-1:0] idx, logic [19:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_MIN) mdl_min_iv = {48'd0, val[15:0]};
        else if (idx == CFG_MAX) mdl_max_iv = {44'd0, val};
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_row make_row(t_op op, logic [3:0] s, logic [63:0] dl,
                                      logic [63:0] per, logic [63:0] now);
        t_row r;
        r.op = op; r.slot = s; r.deadline = dl; r.period = per; r.now = now;
        r.chk = 0; r.alarm = '0; r.upd = 0; r.idle = 0;
        return r;
    endfunction

    // Random item biased toward deadlines near the running clock so ticks fire.
    function automatic t_row random_row();
        t_row r;
        logic [63:0] dl, per;
        int pick;
        pick = $urandom_range(99);
        dl = clock_now + 64'($urandom_range(3000));
        per = ($urandom_range(2) == 0) ? 64'd0 : 64'($urandom_range(1, 900));
        if ($urandom_range(15) == 0) dl = {$urandom, $urandom};
        if ($urandom_range(15) == 0) per = {$urandom, $urandom};
        if (pick < 40) begin
            r = make_row(OP_ARM, 4'($urandom), dl, per, clock_now);
        end else if (pick < 52) begin
            r = make_row(OP_CANCEL, 4'($urandom), dl, per, clock_now);
        end else if (pick < 62) begin
            r = make_row(OP_QUERY, 4'($urandom), dl, per, clock_now);
        end else begin
            // Advance the clock, sometimes a long way or to the end of time.
            if ($urandom_range(19) == 0) clock_now = {$urandom, $urandom};
            else clock_now = add_sat(clock_now, 64'($urandom_range(2500)));
            r = make_row(OP_TICK, 4'($urandom), dl, per, clock_now);
        end
        return r;
    endfunction

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        t_row r;
        for (int i = 0; i < SLOTS; i++) begin
            mdl_deadline[i] = '0; mdl_period[i] = '0; mdl_active[i] = 0;
        end
        mdl_alarm = '0;
        mdl_min_iv = 64'(MIN_RESET);
        mdl_max_iv = 64'(MAX_RESET);

        // Directed table; first rows carry typed-in status values.
        rows[0] = make_row(OP_QUERY, 4'd0, '0, '0, '0);
        rows[0].chk = 1; rows[0].idle = 1;
        rows[1] = make_row(OP_TICK, 4'd0, '0, '0, 64'd1000);
        rows[1].chk = 1; rows[1].upd = 1; rows[1].alarm = 64'd51000;
        rows[2] = make_row(OP_TICK, 4'd15, '0, '0, ALL_ONES);
        rows[2].chk = 1; rows[2].upd = 1; rows[2].alarm = ALL_ONES;
        rows[3] = make_row(OP_ARM, 4'd0, '0, '0, '0);           // deadline zero
        rows[4] = make_row(OP_ARM, 4'd15, ALL_ONES, ALL_ONES, '0);
        rows[5] = make_row(OP_QUERY, 4'd15, '0, '0, '0);
        rows[6] = make_row(OP_TICK, 4'd0, '0, '0, 64'd10);
        rows[7] = make_row(OP_ARM, 4'd3, 64'd100, 64'd0, 64'd10);
        rows[8] = make_row(OP_ARM, 4'd2, 64'd100, 64'd0, 64'd10); // tie, lower slot
        rows[9] = make_row(OP_ARM, 4'd5, 64'd90, 64'd1, 64'd10);  // periodic, overflows
        rows[10] = make_row(OP_TICK, 4'd0, '0, '0, 64'd200);
        rows[11] = make_row(OP_TICK, 4'd0, '0, '0, 64'd200);
        rows[12] = make_row(OP_CANCEL, 4'd5, '0, '0, 64'd200);
        rows[13] = make_row(OP_QUERY, 4'd5, '0, '0, '0);
        rows[14] = make_row(OP_ARM, 4'd7, ALL_ONES - 5, 64'd100, 64'd300); // saturating re-arm
        rows[15] = make_row(OP_TICK, 4'd0, '0, '0, ALL_ONES - 1);
        rows[16] = make_row(OP_TICK, 4'd0, '0, '0, ALL_ONES);
        rows[17] = make_row(OP_ARM, 4'd1, 64'd400, 64'd0, 64'd395); // within min interval
        rows[18] = make_row(OP_ARM, 4'd9, 64'd900, 64'd0, 64'd100);
        rows[19] = make_row(OP_CANCEL, 4'd15, '0, '0, '0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table with reset intervals.
        foreach (rows[k]) begin
            if (rows[k].chk) begin
                wait_drained();
                send_item(rows[k]);
                if (pending_words[$].alarm_time !== rows[k].alarm ||
                    pending_words[$].alarm_update !== rows[k].upd ||
                    pending_words[$].slot_idle !== rows[k].idle) begin
                    mismatches++;
                    if (mismatches <= 10) $display("ERROR: directed row %0d status", k);
                end
            end else begin
                send_item(rows[k]);
            end
        end

        // Random phases under several interval settings, extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: begin write_interval(CFG_MIN, 20'd1); write_interval(CFG_MAX, 20'd1); end
                1: begin write_interval(CFG_MIN, 20'hFFFF); write_interval(CFG_MAX, 20'hFFFFF); end
                2: begin write_interval(CFG_MIN, 20'd0); write_interval(CFG_MAX, 20'd0); end
                3: begin write_interval(CFG_MIN, 20'd2000); write_interval(CFG_MAX, 20'd500); end
                4: begin write_interval(CFG_MAX, 20'($urandom)); write_interval(CFG_MIN, 20'($urandom)); end
                default: begin write_interval(CFG_MIN, 20'd50); write_interval(CFG_MAX, 20'd50000); end
            endcase
            // Phase 1 runs without any idle gaps.
            idle_gaps = (ph != 1);
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                r = random_row();
                send_item(r);
                // Hold off once until every expected word has come back.
                if (ph == 2 && n == 10)
                    while (pending_words.size() != 0) @(negedge i_clk);
            end
        end

        wait_drained();
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
